FILE: src/adler32_rolling_checksum_core_macros.svh
// Assertion macros shared by the checksum core's checker.
`ifndef ADLER32_ROLLING_CHECKSUM_CORE_MACROS_SVH
`define ADLER32_ROLLING_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define ADL_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/adl_pkg.sv
// Shared types, constants and modular helpers for the Adler-32 checksum core.
package adl_pkg;

    localparam logic [15:0] MODULUS       = 16'd65521;
    localparam logic [15:0] MOD_MINUS_ONE = 16'd65520;
    // 2^16 reduced modulo 65521.
    localparam logic [16:0] FOLD_16       = 17'd15;
    localparam logic [15:0] SUM_LOW_RESET = 16'h0001;
    localparam logic [15:0] SUM_HIGH_RESET = 16'h0000;
    localparam logic [15:0] WLEN_RED_RESET = 16'd1024;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_ROLL   = 2'd2;

    // Command class decided by the front end.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_ROLL   = 2'd2,
        CMD_HOLD   = 2'd3
    } cmd_t;

    // Queue entry. For load: arg_a/arg_b are the reduced halves. For append:
    // arg_a is the byte. For roll: arg_a is (in - out) mod M and arg_b is
    // (M - 1 - len*out) mod M.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
    } entry_t;

    function automatic logic [15:0] reduce16(input logic [15:0] v);
        logic [15:0] r;
        r = (v >= MODULUS) ? (v - MODULUS) : v;
        return r;
    endfunction

    // Sum of two values already below the modulus, reduced.
    function automatic logic [15:0] mod_add(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] s;
        s = 17'(x) + 17'(y);
        if (s >= 17'(MODULUS)) begin
            s = s - 17'(MODULUS);
        end
        return s[15:0];
    endfunction

endpackage

FILE: src/adler32_rolling_checksum_core.sv
// Top level of the Adler-32 rolling checksum core.
//
// Input channel (s_*): one transfer carries an operation code (load, append
// or roll), the byte entering, the byte leaving and a 32-bit load value.
// Code 3 leaves the sums alone and still returns the current checksum.
// Result channel (m_*): every input transfer yields exactly one transfer
// of m_checksum = b<<16 | a, taken after the operation, in input order.
// The window length for roll is written through cfg_wr_en/cfg_wr_data and
// is held internally reduced modulo 65521.
// Throughput is one item per cycle while the receiver keeps up. A result is
// registered in the front-end stage, where the window-length product is
// formed and reduced, then in the queue, then in the sums of the sum
// engine, whose add-and-reduce loop updates both sums.
// When the receiver stalls, the checksum holds and the queue of FIFO_DEPTH
// commands fills; input ready falls only when the queue and the front
// stage are both full. Reset (aresetn low, synchronous) empties the queue,
// sets a to 1, b to 0 and the window length to 1024.
module adler32_rolling_checksum_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_operation,
    input  logic [7:0]   s_byte_in,
    input  logic [7:0]   s_byte_out,
    input  logic [31:0]  s_load_value,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [31:0]  m_checksum
);

    // Front end to queue.
    logic             push_valid;
    logic             push_ready;
    adl_pkg::entry_t  push_data;

    // Queue to sum engine.
    logic             pop_valid;
    logic             pop_ready;
    adl_pkg::entry_t  pop_data;

    adl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_byte_in    (s_byte_in),
        .s_byte_out   (s_byte_out),
        .s_load_value (s_load_value),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // The queue lets the front end keep taking items while the receiver
    // holds off the sum engine.
    adl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    adl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_checksum (m_checksum)
    );

endmodule

FILE: src/adl_front.sv
// Front end: accepts items, classifies them and precomputes state-free operands.
module adl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [16:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_byte_in,
    input  logic [7:0]         s_byte_out,
    input  logic [31:0]        s_load_value,
    output logic               push_valid,
    input  logic               push_ready,
    output adl_pkg::entry_t    push_data
);

    logic [15:0]       wlen_red_reg;
    logic [15:0]       wlen_red_next;
    logic [16:0]       wlen_fold;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    adl_pkg::cmd_t     s1_cmd_reg;
    logic [15:0]       s1_arg_a_reg;
    logic [15:0]       s1_arg_b_reg;
    logic [23:0]       s1_prod_reg;

    adl_pkg::cmd_t     cap_cmd;
    logic [15:0]       cap_arg_a;
    logic [15:0]       cap_arg_b;
    logic [16:0]       prod_fold;
    logic [15:0]       len_term;

    // Window length is kept reduced modulo 65521; bit 16 folds in as 15.
    always_comb begin
        wlen_fold     = 17'(cfg_wr_data[15:0]) + (cfg_wr_data[16] ? adl_pkg::FOLD_16 : 17'd0);
        wlen_red_next = (wlen_fold >= 17'(adl_pkg::MODULUS)) ?
                        16'(wlen_fold - 17'(adl_pkg::MODULUS)) : wlen_fold[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_red_reg <= adl_pkg::WLEN_RED_RESET;
        end else if (cfg_wr_en) begin
            wlen_red_reg <= wlen_red_next;
        end
    end

    always_comb begin
        cap_cmd   = adl_pkg::CMD_HOLD;
        cap_arg_a = '0;
        cap_arg_b = '0;
        unique case (s_operation)
            adl_pkg::OP_LOAD: begin
                cap_cmd   = adl_pkg::CMD_LOAD;
                cap_arg_a = adl_pkg::reduce16(s_load_value[15:0]);
                cap_arg_b = adl_pkg::reduce16(s_load_value[31:16]);
            end
            adl_pkg::OP_APPEND: begin
                cap_cmd   = adl_pkg::CMD_APPEND;
                cap_arg_a = {8'd0, s_byte_in};
            end
            adl_pkg::OP_ROLL: begin
                cap_cmd   = adl_pkg::CMD_ROLL;
                cap_arg_a = (s_byte_in >= s_byte_out) ?
                            16'(s_byte_in - s_byte_out) :
                            adl_pkg::MODULUS - 16'(s_byte_out - s_byte_in);
            end
            default: begin
                cap_cmd = adl_pkg::CMD_HOLD;
            end
        endcase
    end

    assign s_ready       = !s1_valid_reg || push_ready;
    assign s1_valid_next = s_ready ? s_valid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_cmd_reg   <= cap_cmd;
            s1_arg_a_reg <= cap_arg_a;
            s1_arg_b_reg <= cap_arg_b;
            s1_prod_reg  <= 24'(wlen_red_reg) * 24'(s_byte_out);
        end
    end

    // Reduce len*out: upper byte weighs 2^16, which is 15 modulo 65521.
    always_comb begin
        prod_fold = 17'(s1_prod_reg[15:0]) + 17'(s1_prod_reg[23:16]) * adl_pkg::FOLD_16;
        len_term  = (prod_fold >= 17'(adl_pkg::MODULUS)) ?
                    16'(prod_fold - 17'(adl_pkg::MODULUS)) : prod_fold[15:0];
    end

    always_comb begin
        push_valid      = s1_valid_reg;
        push_data.cmd   = s1_cmd_reg;
        push_data.arg_a = s1_arg_a_reg;
        push_data.arg_b = (s1_cmd_reg == adl_pkg::CMD_ROLL) ?
                          (adl_pkg::MOD_MINUS_ONE - len_term) : s1_arg_b_reg;
    end

endmodule

FILE: src/adl_fifo.sv
// Short command queue between the front end and the sum engine.
module adl_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  adl_pkg::entry_t    push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output adl_pkg::entry_t    pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    adl_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/adl_back.sv
// Sum engine: applies queued commands to the two sums and presents the checksum.
module adl_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  adl_pkg::entry_t    pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_checksum
);

    logic [15:0] sum_low_reg;
    logic [15:0] sum_low_next;
    logic [15:0] sum_high_reg;
    logic [15:0] sum_high_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        do_pop;

    // The sums double as the output register: a command is only taken once
    // the previous checksum has been transferred.
    assign pop_ready  = !out_valid_reg || m_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign m_valid    = out_valid_reg;
    assign m_checksum = {sum_high_reg, sum_low_reg};

    // The queue head is only decoded while it holds a written entry.
    always_comb begin
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        if (pop_valid) begin
            unique case (pop_data.cmd)
                adl_pkg::CMD_LOAD: begin
                    sum_low_next  = pop_data.arg_a;
                    sum_high_next = pop_data.arg_b;
                end
                adl_pkg::CMD_APPEND: begin
                    sum_low_next  = adl_pkg::mod_add(sum_low_reg, pop_data.arg_a);
                    sum_high_next = adl_pkg::mod_add(sum_high_reg, sum_low_next);
                end
                adl_pkg::CMD_ROLL: begin
                    sum_low_next  = adl_pkg::mod_add(sum_low_reg, pop_data.arg_a);
                    sum_high_next = adl_pkg::mod_add(
                        adl_pkg::mod_add(sum_high_reg, sum_low_next), pop_data.arg_b);
                end
                adl_pkg::CMD_HOLD: begin
                    sum_low_next  = sum_low_reg;
                    sum_high_next = sum_high_reg;
                end
            endcase
        end
    end

    assign out_valid_next = do_pop ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_low_reg   <= adl_pkg::SUM_LOW_RESET;
            sum_high_reg  <= adl_pkg::SUM_HIGH_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (do_pop) begin
                sum_low_reg  <= sum_low_next;
                sum_high_reg <= sum_high_next;
            end
        end
    end

endmodule

FILE: src/adl_checker.sv
// Port-level checker for the Adler-32 checksum core, with its bind statement.
`include "adler32_rolling_checksum_core_macros.svh"

module adl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_valid,
    input logic         s_ready,
    input logic         m_valid,
    input logic         m_ready,
    input logic [31:0]  m_checksum
);

    // Items accepted whose result has not yet been transferred.
    logic [7:0] outstanding_reg;
    logic [7:0] outstanding_next;
    logic       m_stalled;
    logic       halves_reduced;

    assign m_stalled      = m_valid && !m_ready;
    assign halves_reduced = (m_checksum[15:0] < adl_pkg::MODULUS) &&
                            (m_checksum[31:16] < adl_pkg::MODULUS);

    always_comb begin
        outstanding_next = outstanding_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            outstanding_next = outstanding_reg + 8'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            outstanding_next = outstanding_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    `ADL_ASSERT_NEXT(a_result_holds, m_stalled, m_valid && $stable(m_checksum), "stall not held")
    `ADL_ASSERT_IMPL(a_sums_reduced, m_valid, halves_reduced, "checksum half not reduced")
    `ADL_ASSERT_IMPL(a_no_extra_result, m_valid, outstanding_reg != 8'd0, "unrequested result")
    `ADL_ASSERT_RESET(a_reset_state, !aresetn, !m_valid && s_ready, "bad state after reset")

endmodule

bind adler32_rolling_checksum_core adl_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_checksum (m_checksum)
);

FILE: tb/sv/tb_adler32_rolling_checksum_core.sv
// Self-checking testbench for the Adler-32 rolling checksum core.
`timescale 1ns / 100ps

module tb_adler32_rolling_checksum_core;

    // Operation code 3 has no name in the package; the core leaves the sums alone.
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam logic [31:0] MOD32           = 32'd65521;
    localparam int          N_DIRECTED      = 22;
    localparam int          N_PHASES        = 8;
    localparam int          ITEMS_PER_PHASE = 235;
    localparam int          HOLD_OFF_CYCLES = 64;
    localparam int          DRAIN_LIMIT     = 10000;

    // One row of the directed table. When known is set, checksum is the value
    // read straight off the algorithm; otherwise the predictor supplies it.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_new;
        logic [7:0]  byte_old;
        logic [31:0] load_word;
        logic        known;
        logic [31:0] checksum;
    } stim_row_t;

    // The window length starts at its reset value of 1024 for the whole table.
    stim_row_t directed_rows [N_DIRECTED] = '{
        // Code 3 straight after reset returns the empty-buffer value.
        '{OP_UNUSED,          8'h00, 8'h00, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{adl_pkg::OP_APPEND, 8'h00, 8'h00, 32'h0000_0000, 1'b1, 32'h0001_0001},
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'h0000_0001, 1'b1, 32'h0000_0001},
        '{adl_pkg::OP_APPEND, 8'hFF, 8'h00, 32'h0000_0000, 1'b1, 32'h0100_0100},
        // Halves above the modulus are reduced by a single subtraction.
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'h000E_000E},
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'hFFF0_FFF0, 1'b1, 32'hFFF0_FFF0},
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'hFFF1_FFF1, 1'b1, 32'h0000_0000},
        // Both sums wrap on the largest byte from the largest state.
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'hFFF0_FFF0, 1'b1, 32'hFFF0_FFF0},
        '{adl_pkg::OP_APPEND, 8'hFF, 8'h00, 32'h0000_0000, 1'b1, 32'h00FD_00FE},
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // Rolling zeros out of an all-zero state leaves b at the modulus minus one.
        '{adl_pkg::OP_ROLL,   8'h00, 8'h00, 32'h0000_0000, 1'b1, 32'hFFF0_0000},
        '{adl_pkg::OP_ROLL,   8'hFF, 8'hFF, 32'h0000_0000, 1'b0, 32'h0},
        '{adl_pkg::OP_ROLL,   8'hFF, 8'h00, 32'h0000_0000, 1'b0, 32'h0},
        '{adl_pkg::OP_ROLL,   8'h00, 8'hFF, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_UNUSED,          8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{adl_pkg::OP_LOAD,   8'h00, 8'h00, 32'h0001_FFFF, 1'b0, 32'h0},
        '{adl_pkg::OP_LOAD,   8'hFF, 8'hFF, 32'hFFFF_0001, 1'b0, 32'h0},
        '{adl_pkg::OP_APPEND, 8'h80, 8'h5A, 32'hA5A5_A5A5, 1'b0, 32'h0},
        '{adl_pkg::OP_ROLL,   8'h55, 8'hAA, 32'h5A5A_5A5A, 1'b0, 32'h0},
        '{adl_pkg::OP_APPEND, 8'h01, 8'hFF, 32'h0000_0000, 1'b0, 32'h0},
        '{adl_pkg::OP_ROLL,   8'h7F, 8'h80, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_UNUSED,          8'h00, 8'h00, 32'h0000_0000, 1'b0, 32'h0}
    };

    // Window lengths used by the random phases, extremes and out-of-range
    // values among them. The last one is replaced by a random value.
    logic [16:0] window_settings [N_PHASES] = '{
        17'd1, 17'd65536, 17'd0, 17'd131071, 17'd65521, 17'd65520, 17'd2, 17'd1024
    };

    // Block ports; every input has a known value from time zero.
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [16:0] cfg_wr_data  = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation  = adl_pkg::OP_LOAD;
    logic [7:0]  s_byte_in    = '0;
    logic [7:0]  s_byte_out   = '0;
    logic [31:0] s_load_value = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_checksum;

    // Typed-in expectation that travels with the item currently offered.
    logic        offer_known    = 1'b0;
    logic [31:0] offer_checksum = '0;

    // Predictor state, in step with the core's sums and window register.
    logic [15:0] model_sum_a      = 16'd1;
    logic [15:0] model_sum_b      = 16'd0;
    logic [16:0] model_window_len = 17'd1024;

    logic [31:0] pending_checksums [$];
    logic [31:0] predicted_sum;
    logic [31:0] oldest_checksum;
    int          mismatch_count    = 0;
    int          send_idle_pct     = 0;
    int          recv_stall_pct    = 0;
    int          hold_off_requests = 0;

    adler32_rolling_checksum_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_byte_in    (s_byte_in),
        .s_byte_out   (s_byte_out),
        .s_load_value (s_load_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_checksum   (m_checksum)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // Hard stop in case the core deadlocks or drops transfers.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Applies one operation to the predictor's sums and returns the checksum
    // that the core should report afterwards. All arithmetic is done in 32 bits,
    // which is ample: the largest intermediate is below 255 times the modulus.
    function automatic logic [31:0] next_checksum(input logic [1:0] op,
                                                  input logic [7:0] byte_new,
                                                  input logic [7:0] byte_old,
                                                  input logic [31:0] load_word);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] drop;
        logic [31:0] acc;
        case (op)
            adl_pkg::OP_LOAD: begin
                lo = {16'd0, load_word[15:0]};
                hi = {16'd0, load_word[31:16]};
                // A half can exceed the modulus by at most 14, so one
                // subtraction always brings it into range.
                if (lo >= MOD32) begin
                    lo = lo - MOD32;
                end
                if (hi >= MOD32) begin
                    hi = hi - MOD32;
                end
                model_sum_a = lo[15:0];
                model_sum_b = hi[15:0];
            end
            adl_pkg::OP_APPEND: begin
                acc = (32'(model_sum_a) + 32'(byte_new)) % MOD32;
                model_sum_a = acc[15:0];
                // b accumulates the updated a, not the old one.
                acc = (32'(model_sum_b) + 32'(model_sum_a)) % MOD32;
                model_sum_b = acc[15:0];
            end
            adl_pkg::OP_ROLL: begin
                acc = (32'(model_sum_a) + MOD32 - 32'(byte_old) + 32'(byte_new)) % MOD32;
                model_sum_a = acc[15:0];
                // The leaving byte was counted window-length times in b. The
                // register is taken modulo the modulus, so zero and values
                // above 65536 are legal.
                drop = ((32'(model_window_len) % MOD32) * 32'(byte_old)) % MOD32;
                acc = 32'(model_sum_b) + 32'(model_sum_a) + 32'd2 * MOD32 - drop - 32'd1;
                acc = acc % MOD32;
                model_sum_b = acc[15:0];
            end
            default: begin
                // Unused code: the sums stay as they are.
            end
        endcase
        return {model_sum_b, model_sum_a};
    endfunction

    // Scoreboard. Config writes, input transfers and result transfers are all
    // sampled at the same clock edge in one block, so the order of predicting
    // and checking never depends on the simulator's scheduling.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                model_window_len = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                predicted_sum = next_checksum(s_operation, s_byte_in, s_byte_out,
                                              s_load_value);
                pending_checksums.push_back(offer_known ? offer_checksum : predicted_sum);
            end
            if (m_valid && m_ready) begin
                if (pending_checksums.size() == 0) begin
                    $display("%0t: checksum transfer with none pending: expected none, actual %h",
                             $time, m_checksum);
                    mismatch_count++;
                end else begin
                    oldest_checksum = pending_checksums.pop_front();
                    if (m_checksum !== oldest_checksum) begin
                        $display("%0t: checksum mismatch: expected %h, actual %h",
                                 $time, oldest_checksum, m_checksum);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Result side. Stalls at the rate of the current phase, and on request
    // holds off for a long stretch so that the core's queue fills and it
    // drops s_ready while the sender keeps offering.
    initial begin
        int hold_left;
        int holds_granted;
        hold_left = 0;
        holds_granted = 0;
        forever begin
            @(posedge aclk);
            if (holds_granted < hold_off_requests) begin
                holds_granted++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one item and returns at the edge where it is accepted. An idle
    // gap, if any, comes first; otherwise s_valid simply stays high into the
    // next transfer.
    task automatic send_item(input logic [1:0] op, input logic [7:0] byte_new,
                             input logic [7:0] byte_old, input logic [31:0] load_word,
                             input logic known, input logic [31:0] known_sum);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_byte_in      <= byte_new;
        s_byte_out     <= byte_old;
        s_load_value   <= load_word;
        offer_known    <= known;
        offer_checksum <= known_sum;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Bytes lean toward the extremes so that wrap-around is hit often.
    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    // Mostly appends and rolls, with loads sprinkled in to reset the sums to
    // arbitrary points and the unused code now and then.
    task automatic send_random_item();
        int          pick;
        logic [1:0]  op;
        logic [31:0] load_word;
        pick = $urandom_range(99);
        if (pick < 10) begin
            op = adl_pkg::OP_LOAD;
        end else if (pick < 50) begin
            op = adl_pkg::OP_APPEND;
        end else if (pick < 90) begin
            op = adl_pkg::OP_ROLL;
        end else begin
            op = OP_UNUSED;
        end
        load_word = $urandom();
        // In a quarter of the cases each half is forced to a value that needs reducing.
        if ($urandom_range(3) == 0) begin
            load_word[15:0] = 16'($urandom_range(65535, 65521));
        end
        if ($urandom_range(3) == 0) begin
            load_word[31:16] = 16'($urandom_range(65535, 65521));
        end
        send_item(op, random_byte(), random_byte(), load_word, 1'b0, 32'h0);
    endtask

    // Waits, with a limit, until every predicted checksum has come back. The
    // first edge lets the scoreboard record the last accepted item before the
    // count is read.
    task automatic drain_results();
        int spins;
        spins = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_checksums.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // Single-cycle write pulse; only issued while the core is idle.
    task automatic write_window_length(input logic [16:0] len);
        cfg_wr_data <= len;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Main sequence: reset, the directed table at full rate, then random
    // phases that each pick a window length and a pattern of idle cycles.
    initial begin
        int row;
        int phase;
        int item;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < N_DIRECTED; row++) begin
            send_item(directed_rows[row].op, directed_rows[row].byte_new,
                      directed_rows[row].byte_old, directed_rows[row].load_word,
                      directed_rows[row].known, directed_rows[row].checksum);
        end

        window_settings[N_PHASES - 1] = 17'($urandom_range(131071));
        for (phase = 0; phase < N_PHASES; phase++) begin
            drain_results();
            write_window_length(window_settings[phase]);
            case (phase % 4)
                0: begin
                    // Full rate on both sides, opened by a long receiver hold-off.
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_off_requests++;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                send_random_item();
            end
        end

        recv_stall_pct = 0;
        drain_results();
        if (pending_checksums.size() != 0) begin
            $display("%0t: checksums never returned: expected %0d more, actual 0",
                     $time, pending_checksums.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
